// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the rasterizer RTL.
// Define NO_ASSERTIONS to compile the design without them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPR_ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
`define LPR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define LPR_ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg)
`define LPR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== hdl/lpr_pkg.sv =====
// Package for the line pixel address rasterizer: field widths, beat types,
// register indexes and the shared multiplier request type. No dependencies.
`timescale 1ns / 1ps

package lpr_pkg;

	localparam int COORD_W        = 12;
	localparam int FRAC_W         = 6;
	localparam int SCALE_W        = 5;
	localparam int STRIDE_W       = 13;
	localparam int COLOR_W        = 32;
	localparam int ADDR_W         = 18;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;
	localparam int MAP_PIXELS_DEF = 64;

	localparam int MUL_A_W = COORD_W;
	localparam int MUL_B_W = STRIDE_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(1);
	localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(1024);
	localparam logic [COLOR_W-1:0]  COLOR_RST  = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_SCALE = 2'd0,
		REG_ROW_STRIDE  = 2'd1,
		REG_DRAW_COLOR  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} in_beat_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  pixel_address;
		logic [COLOR_W-1:0] pixel_value;
		logic               last_pixel;
	} out_beat_t;

	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
		logic [MUL_A_W-1:0] c;
	} mul_req_t;

endpackage

// ===== hdl/lpr_mul_unit.sv =====
// Shared multiply-add unit of the rasterizer: a * b + c, combinational.
// Serves both coordinate scaling and pixel address generation. Uses lpr_pkg.
`timescale 1ns / 1ps

module lpr_mul_unit (
	input  lpr_pkg::mul_req_t              req,
	output logic [lpr_pkg::MUL_P_W-1:0]    res
);
	import lpr_pkg::*;

	logic [MUL_P_W-1:0] prod;

	assign prod = MUL_P_W'(req.a) * MUL_P_W'(req.b);
	assign res  = prod + MUL_P_W'(req.c);

endmodule

// ===== hdl/line_pixel_address_rasterizer.sv =====
// Top level of the line pixel address rasterizer: configuration registers,
// sequencer, line stepper and output register. Uses lpr_pkg, lpr_mul_unit
// and assert_macros.svh.
//
//   Channel   Direction  Handshake            Payload
//   in        input      in_valid/in_ready    in_beat_t, one line segment
//   out       output     out_valid/out_ready  out_beat_t, one pixel
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// After acceptance the four coordinates are scaled in S_SCALE through the shared
// multiplier, S_SETUP sets up the deltas, then in S_WALK one pixel per cycle, while
// out is not stalled, goes through the same multiplier to form its address. A line
// has N pixels, N from 0 to MAP_PIXELS-1.
// A stall on out holds the stepper; in_ready is high only while idle.
// Reset returns the block to idle and the registers to scale 1, stride 1024,
// color 0.
`timescale 1ns / 1ps

module line_pixel_address_rasterizer #(
	parameter int MAP_PIXELS = lpr_pkg::MAP_PIXELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  lpr_pkg::in_beat_t               in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lpr_pkg::out_beat_t              out_data,
	input  logic                            cfg_we,
	input  logic [lpr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lpr_pkg::*;

	`include "assert_macros.svh"

	localparam int CW = $clog2(MAP_PIXELS);
	localparam int EW = CW + 2;
	localparam int VW = MUL_P_W - FRAC_W;
	localparam logic [CW-1:0] PIX_MAX = CW'(MAP_PIXELS - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCALE = 4'b0010,
		S_SETUP = 4'b0100,
		S_WALK  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [SCALE_W-1:0] pixel_scale_q;
	logic [STRIDE_W-1:0] row_stride_q;
	logic [COLOR_W-1:0] draw_color_q;

	logic [COORD_W-1:0] coord_q [4];
	logic [CW-1:0]      pix_q [4];
	logic [1:0]         sel_q;

	logic [CW-1:0] cur_x_q, cur_y_q;
	logic [CW-1:0] span_major_q, span_minor_q, remain_q;
	logic [EW-1:0] err_q;
	logic          x_down_q, y_down_q, x_major_q;

	logic          out_valid_q;
	out_beat_t     out_q;

	mul_req_t           mreq;
	logic [MUL_P_W-1:0] mres;
	logic [VW-1:0]      scaled;
	logic [CW-1:0]      scaled_pix;

	logic [CW-1:0] dx, dy;
	logic          x_down, y_down, x_major;
	logic          emit, last;
	logic [EW-1:0] err_inc, thresh;
	logic          minor_step;

	lpr_mul_unit u_mul (
		.req (mreq),
		.res (mres)
	);

	always_comb begin
		if (state_q == S_SCALE) begin
			mreq.a = coord_q[sel_q];
			mreq.b = MUL_B_W'(pixel_scale_q);
			mreq.c = '0;
		end else begin
			mreq.a = MUL_A_W'(cur_y_q);
			mreq.b = row_stride_q;
			mreq.c = MUL_A_W'(cur_x_q);
		end
	end

	assign scaled     = mres[MUL_P_W-1:FRAC_W];
	assign scaled_pix = (scaled > VW'(PIX_MAX)) ? PIX_MAX : scaled[CW-1:0];

	assign x_down  = pix_q[2] < pix_q[0];
	assign y_down  = pix_q[3] < pix_q[1];
	assign dx      = x_down ? pix_q[0] - pix_q[2] : pix_q[2] - pix_q[0];
	assign dy      = y_down ? pix_q[1] - pix_q[3] : pix_q[3] - pix_q[1];
	assign x_major = dy <= dx;

	assign in_ready   = (state_q == S_IDLE);
	assign emit       = (state_q == S_WALK) && (!out_valid_q || out_ready);
	assign last       = (remain_q == CW'(1));
	assign err_inc    = err_q + EW'(span_minor_q) + EW'(1);
	assign thresh     = EW'(span_major_q) + EW'(1);
	assign minor_step = err_inc >= thresh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_scale_q <= SCALE_RST;
			row_stride_q  <= STRIDE_RST;
			draw_color_q  <= COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_SCALE: pixel_scale_q <= cfg_data[SCALE_W-1:0];
				REG_ROW_STRIDE:  row_stride_q  <= cfg_data[STRIDE_W-1:0];
				REG_DRAW_COLOR:  draw_color_q  <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCALE;
						sel_q   <= '0;
					end
				end
				S_SCALE: begin
					sel_q <= sel_q + 2'd1;
					if (sel_q == 2'd3) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if ((x_major ? dx : dy) == '0) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (emit && last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			coord_q[0] <= in_data.start_x;
			coord_q[1] <= in_data.start_y;
			coord_q[2] <= in_data.end_x;
			coord_q[3] <= in_data.end_y;
		end
		if (state_q == S_SCALE) begin
			pix_q[sel_q] <= scaled_pix;
		end
		if (state_q == S_SETUP) begin
			cur_x_q      <= pix_q[0];
			cur_y_q      <= pix_q[1];
			err_q        <= '0;
			x_down_q     <= x_down;
			y_down_q     <= y_down;
			x_major_q    <= x_major;
			span_major_q <= x_major ? dx : dy;
			span_minor_q <= x_major ? dy : dx;
			remain_q     <= x_major ? dx : dy;
		end
		if (emit) begin
			out_q.pixel_address <= mres[ADDR_W-1:0];
			out_q.pixel_value   <= draw_color_q;
			out_q.last_pixel    <= last;
			remain_q            <= remain_q - CW'(1);
			err_q               <= minor_step ? err_inc - thresh : err_inc;
			if (x_major_q) begin
				cur_x_q <= x_down_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
				if (minor_step) begin
					cur_y_q <= y_down_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
				end
			end else begin
				cur_y_q <= y_down_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
				if (minor_step) begin
					cur_x_q <= x_down_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LPR_ASSERT_NEXT(a_accept_starts_scale, clk, arst_n, in_valid && in_ready, state_q == S_SCALE, "accepted line did not start scaling")
	`LPR_ASSERT_NEXT(a_last_ends_line, clk, arst_n, emit && last, state_q == S_IDLE && out_valid_q, "last pixel did not end the line")
	`LPR_ASSERT_IMPLIES(a_walk_has_pixels, clk, arst_n, state_q == S_WALK, remain_q != '0, "stepper walking with no pixels left")
	`LPR_ASSERT_IMPLIES(a_err_below_thresh, clk, arst_n, state_q == S_WALK, err_q <= EW'(span_major_q), "error accumulator reached threshold")

endmodule

// ===== verif/tb_line_pixel_address_rasterizer.sv =====
// Testbench for line_pixel_address_rasterizer: drives line segments and register writes,
// predicts every pixel beat of each line and checks them in order.
// Depends on lpr_pkg and the rasterizer RTL only.
`timescale 1ns / 1ps

module tb_line_pixel_address_rasterizer;
	import lpr_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 8;
	localparam int PIX_W           = 6;
	localparam int PROD_W          = COORD_W + SCALE_W;
	localparam int ADDR_FULL_W     = ADDR_W + 2;
	localparam int PIXEL_LIMIT     = MAP_PIXELS_DEF - 1;
	localparam int SETTLE_CYCLES   = 16;
	localparam int STALL_LIMIT     = 2000;
	localparam int RANDOM_BLOCKS   = 6;
	localparam int LINES_PER_BLOCK = 35;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_beat_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_beat_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [SCALE_W-1:0]  scale_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [COLOR_W-1:0]  color_q;

	out_beat_t pending_pixels[$];
	int error_count   = 0;
	int quiet_cycles  = 0;
	int send_idle_pct = 33;
	int recv_idle_pct = 52;

	line_pixel_address_rasterizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic [PIX_W-1:0] to_minimap(input logic [COORD_W-1:0] q);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(q) * PROD_W'(scale_q);
		if (prod[PROD_W-1:FRAC_W] > (PROD_W-FRAC_W)'(PIXEL_LIMIT))
			return PIX_W'(PIXEL_LIMIT);
		return prod[FRAC_W +: PIX_W];
	endfunction

	function automatic void rasterize_line(input in_beat_t seg);
		logic [PIX_W-1:0]  x0, y0, x1, y1, px, py, dx, dy, span_maj, span_min, goal;
		logic [7:0]        err;
		logic [ADDR_W+1:0] addr_full;
		logic              x_major, x_down, y_down;
		out_beat_t         pix;
		int                n;
		x0 = to_minimap(seg.start_x);
		y0 = to_minimap(seg.start_y);
		x1 = to_minimap(seg.end_x);
		y1 = to_minimap(seg.end_y);
		x_down = x1 < x0;
		y_down = y1 < y0;
		dx = x_down ? x0 - x1 : x1 - x0;
		dy = y_down ? y0 - y1 : y1 - y0;
		x_major = dy <= dx;
		span_maj = x_major ? dx : dy;
		span_min = x_major ? dy : dx;
		goal = x_major ? x1 : y1;
		px = x0;
		py = y0;
		err = '0;
		n = 0;
		while (n < PIXEL_LIMIT && (x_major ? px : py) != goal) begin
			addr_full = ADDR_FULL_W'(py) * ADDR_FULL_W'(stride_q) + ADDR_FULL_W'(px);
			pix.pixel_address = addr_full[ADDR_W-1:0];
			pix.pixel_value = color_q;
			pix.last_pixel = 1'b0;
			pending_pixels.push_back(pix);
			n++;
			err = err + span_min + 8'd1;
			if (err >= {2'b00, span_maj} + 8'd1) begin
				err = err - ({2'b00, span_maj} + 8'd1);
				if (x_major)
					py = y_down ? py - PIX_W'(1) : py + PIX_W'(1);
				else
					px = x_down ? px - PIX_W'(1) : px + PIX_W'(1);
			end
			if (x_major)
				px = x_down ? px - PIX_W'(1) : px + PIX_W'(1);
			else
				py = y_down ? py - PIX_W'(1) : py + PIX_W'(1);
		end
		if (n > 0) begin
			pix = pending_pixels.pop_back();
			pix.last_pixel = 1'b1;
			pending_pixels.push_back(pix);
		end
	endfunction

	function automatic in_beat_t random_segment();
		in_beat_t seg;
		int       reach;
		int       kind;
		reach = (scale_q == 0) ? 4095 : (4096 / scale_q) + 64;
		if (reach > 4095)
			reach = 4095;
		kind = $urandom_range(0, 9);
		seg.start_x = COORD_W'($urandom_range(0, reach));
		seg.start_y = COORD_W'($urandom_range(0, reach));
		seg.end_x = COORD_W'($urandom_range(0, reach));
		seg.end_y = COORD_W'($urandom_range(0, reach));
		if (kind < 3) begin
			seg.start_x = COORD_W'($urandom_range(0, 4095));
			seg.start_y = COORD_W'($urandom_range(0, 4095));
			seg.end_x = COORD_W'($urandom_range(0, 4095));
			seg.end_y = COORD_W'($urandom_range(0, 4095));
		end else if (kind == 3) begin
			seg.end_x = seg.start_x;
			seg.end_y = seg.start_y;
		end else if (kind == 4) begin
			seg.end_x = seg.start_x ^ COORD_W'($urandom_range(0, 127));
			seg.end_y = seg.start_y ^ COORD_W'($urandom_range(0, 127));
		end
		return seg;
	endfunction

	task automatic send_line(input in_beat_t seg);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = seg;
		do
			@(posedge clk);
		while (!in_ready);
		rasterize_line(seg);
		@(negedge clk);
	endtask

	task automatic wait_for_idle();
		in_valid = 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		case (idx)
			REG_PIXEL_SCALE: scale_q = value[SCALE_W-1:0];
			REG_ROW_STRIDE:  stride_q = value[STRIDE_W-1:0];
			REG_DRAW_COLOR:  color_q = value[COLOR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_reset_registers();
		send_line('{12'd0, 12'd0, 12'd0, 12'd0});
		send_line('{12'd0, 12'd0, 12'd4095, 12'd0});
		send_line('{12'd4095, 12'd4095, 12'd0, 12'd0});
		send_line('{12'd0, 12'd0, 12'd0, 12'd4095});
		send_line('{12'd4095, 12'd0, 12'd0, 12'd4095});
		send_line('{12'd1000, 12'd0, 12'd0, 12'd4095});
		send_line('{12'd0, 12'd4095, 12'd4095, 12'd1000});
		send_line('{12'd63, 12'd63, 12'd0, 12'd0});
		wait_for_idle();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_PIXEL_SCALE, 32'd31);
		write_reg(REG_ROW_STRIDE, 32'h1FFF);
		write_reg(REG_DRAW_COLOR, 32'hFFFF_FFFF);
		send_line('{12'd0, 12'd0, 12'd4095, 12'd4095});
		send_line('{12'd4095, 12'd4095, 12'd0, 12'd130});
		send_line('{12'd200, 12'd0, 12'd200, 12'd4095});
		wait_for_idle();
		write_reg(REG_PIXEL_SCALE, 32'd0);
		write_reg(REG_ROW_STRIDE, 32'd64);
		write_reg(REG_DRAW_COLOR, 32'd0);
		send_line('{12'd4095, 12'd0, 12'd0, 12'd4095});
		send_line('{12'd4095, 12'd4095, 12'd4095, 12'd4095});
		wait_for_idle();
	endtask

	task automatic test_register_masking();
		write_reg(REG_PIXEL_SCALE, 32'hFFFF_FFF0);
		write_reg(REG_ROW_STRIDE, 32'hFFFF_F000);
		write_reg(REG_DRAW_COLOR, 32'h1234_5678);
		write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
		send_line('{12'd0, 12'd0, 12'd252, 12'd100});
		send_line('{12'd252, 12'd252, 12'd0, 12'd0});
		send_line('{12'd10, 12'd0, 12'd0, 12'd250});
		wait_for_idle();
		write_reg(REG_PIXEL_SCALE, 32'd1);
		send_line('{12'd4095, 12'd4095, 12'd0, 12'd4095});
		wait_for_idle();
	endtask

	task automatic apply_random_settings();
		int pick;
		pick = $urandom_range(0, 9);
		write_reg(REG_PIXEL_SCALE, pick == 0 ? 0 : pick == 1 ? 31 : pick == 2 ? 1 :
			$urandom_range(1, 16));
		pick = $urandom_range(0, 9);
		write_reg(REG_ROW_STRIDE, pick < 2 ? 64 : pick < 4 ? 4096 : pick == 4 ? 8191 :
			$urandom_range(64, 4096));
		write_reg(REG_DRAW_COLOR, $urandom);
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNMAPPED, $urandom);
	endtask

	task automatic test_random_lines();
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			if (blk < 2) begin
				send_idle_pct = 33;
				recv_idle_pct = 52;
			end else if (blk < 4) begin
				send_idle_pct = 52;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			apply_random_settings();
			for (int i = 0; i < LINES_PER_BLOCK; i++) begin
				send_line(random_segment());
				if ($urandom_range(0, 19) == 0)
					wait_for_idle();
			end
			wait_for_idle();
		end
	endtask

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		out_beat_t due;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t: unexpected pixel beat addr %0h value %0h last %0b", $time,
						out_data.pixel_address, out_data.pixel_value, out_data.last_pixel);
					error_count++;
				end else begin
					due = pending_pixels.pop_front();
					if (out_data.pixel_address !== due.pixel_address ||
						out_data.pixel_value !== due.pixel_value ||
						out_data.last_pixel !== due.last_pixel) begin
						$display("%0t: expected addr %0h value %0h last %0b, got addr %0h value %0h last %0b",
							$time, due.pixel_address, due.pixel_value, due.last_pixel,
							out_data.pixel_address, out_data.pixel_value, out_data.last_pixel);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		scale_q = SCALE_RST;
		stride_q = STRIDE_RST;
		color_q = COLOR_RST;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		test_reset_registers();
		test_register_extremes();
		test_register_masking();
		test_random_lines();
		wait_for_idle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
